FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the tachometer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of clk outside reset.
`define SPT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition never holds on a rising edge of clk outside reset.
`define SPT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

FILE: hw/rtl/sptach_pkg.sv
// Types, widths and constants of the spindle period tachometer.
package sptach_pkg;

  localparam int TIME_BITS = 32;
  localparam int TS_W      = 32;
  localparam int OP_W      = 2;
  localparam int SYNC_W    = 15;
  localparam int SPEED_W   = 16;
  localparam int RPM_W     = 16;
  localparam int FEED_W    = 31;

  localparam int SPEED_NUM = 100000000;
  localparam int NUM_BITS  = $clog2(SPEED_NUM + 1);

  localparam int RPM_X_W   = SPEED_W + 2;
  localparam int RPM_DIV   = 5;
  localparam int RPM_REM_W = $clog2(RPM_DIV);

  localparam int MUL_STEPS = SYNC_W;
  localparam int RPM_STEPS = RPM_X_W;
  localparam int RES_CNT_W = $clog2(RPM_STEPS + 1);
  localparam int DIV_CNT_W = $clog2(NUM_BITS + 1);

  localparam logic [OP_W-1:0] OP_PULSE   = 2'd0;
  localparam logic [OP_W-1:0] OP_RESTART = 2'd1;
  localparam logic [OP_W-1:0] OP_STATUS  = 2'd2;

  localparam logic [SPEED_W-1:0] SPEED_MAX = '1;

  typedef struct packed {
    logic                 start;
    logic [TIME_BITS-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic               sat;
    logic [SPEED_W-1:0] quot;
  } div_rsp_t;

  typedef struct packed {
    logic               start;
    logic [SPEED_W-1:0] speed;
    logic [SYNC_W-1:0]  sync;
  } res_req_t;

  typedef struct packed {
    logic              done;
    logic [RPM_W-1:0]  rpm;
    logic [FEED_W-1:0] feed;
  } res_rsp_t;

endpackage

FILE: hw/rtl/spindle_period_tachometer_top.sv
// Spindle period tachometer: top level with control sequencer and result register.
//
// Input channel (in_valid / in_stall): one item carries an opcode (spindle pulse,
// restart warm-up or status read), a microsecond timestamp and a feed sync speed.
// An item is taken on an edge with in_valid high and in_stall low. The block holds
// one item at a time and raises in_stall from acceptance until its result has been
// placed in the output register.
// Result channel (out_valid / out_stall): one result per item with the held speed,
// rpm, feed product, ready flag and saturation flag; a result is taken on an edge
// with out_valid high and out_stall low, and holds while out_stall is high.
// A measured pulse runs the serial divider (27 steps, one quotient bit a cycle)
// and then the serial result unit (18 steps); other items skip the divider.
// in_stall falls in the same cycle as out_valid rises, so the next item can be
// taken while its predecessor's result is still offered on the output.
// The result register lets the next item enter while a result waits under stall.
// Reset (rst_n low, synchronous) clears the last pulse time, phase and speed, sets
// warm-up, and empties the result register.
`include "assert_macros.svh"

module spindle_period_tachometer_top
  import sptach_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [OP_W-1:0]     in_opcode,
  input  logic [TS_W-1:0]     in_timestamp_us,
  input  logic [SYNC_W-1:0]   in_feed_sync_speed,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [SPEED_W-1:0]  out_rps_x100,
  output logic [RPM_W-1:0]    out_rpm,
  output logic [FEED_W-1:0]   out_feed_product,
  output logic                out_ready_res,
  output logic                out_saturated
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_RES,
    S_HOLD
  } state_t;

  state_t                state_r;
  logic [TIME_BITS-1:0]  last_time_r;
  logic [TIME_BITS-1:0]  delta_r;
  logic                  phase_r;
  logic                  warming_r;
  logic [SPEED_W-1:0]    speed_r;
  logic                  sat_r;
  logic [SYNC_W-1:0]     sync_r;
  logic                  div_start_r;
  logic                  res_start_r;
  logic                  out_valid_r;
  logic [SPEED_W-1:0]    out_rps_r;
  logic [RPM_W-1:0]      out_rpm_r;
  logic [FEED_W-1:0]     out_feed_r;
  logic                  out_ready_r;
  logic                  out_sat_r;

  logic                  in_acc;
  logic                  out_free;
  logic [TIME_BITS-1:0]  ts;
  logic [TIME_BITS-1:0]  delta_nxt;
  div_req_t              div_req;
  div_rsp_t              div_rsp;
  res_req_t              res_req;
  res_rsp_t              res_rsp;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign ts        = TIME_BITS'(in_timestamp_us);
  assign delta_nxt = ts - last_time_r;

  assign div_req.start = div_start_r;
  assign div_req.den   = delta_r;
  assign res_req.start = res_start_r;
  assign res_req.speed = speed_r;
  assign res_req.sync  = sync_r;

  sptach_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  sptach_res u_res (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (res_req),
    .rsp   (res_rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      last_time_r <= '0;
      phase_r     <= 1'b0;
      warming_r   <= 1'b1;
      speed_r     <= '0;
      sat_r       <= 1'b0;
      div_start_r <= 1'b0;
      res_start_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      div_start_r <= 1'b0;
      res_start_r <= 1'b0;
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            sync_r <= in_feed_sync_speed;
            sat_r  <= 1'b0;
            state_r     <= S_RES;
            res_start_r <= 1'b1;
            unique case (in_opcode)
              OP_PULSE: begin
                last_time_r <= ts;
                delta_r     <= delta_nxt;
                phase_r     <= !phase_r;
                if (phase_r) begin
                  warming_r <= 1'b0;
                end
                if (!warming_r) begin
                  if (delta_nxt == '0) begin
                    speed_r <= SPEED_MAX;
                    sat_r   <= 1'b1;
                  end else begin
                    res_start_r <= 1'b0;
                    div_start_r <= 1'b1;
                    state_r     <= S_DIV;
                  end
                end
              end
              OP_RESTART: begin
                warming_r <= 1'b1;
              end
              default: begin
              end
            endcase
          end
        end
        S_DIV: begin
          if (div_rsp.done) begin
            speed_r     <= div_rsp.quot;
            sat_r       <= div_rsp.sat;
            res_start_r <= 1'b1;
            state_r     <= S_RES;
          end
        end
        S_RES: begin
          if (res_rsp.done) begin
            if (out_free) begin
              out_valid_r <= 1'b1;
              out_rps_r   <= speed_r;
              out_rpm_r   <= res_rsp.rpm;
              out_feed_r  <= res_rsp.feed;
              out_ready_r <= !warming_r;
              out_sat_r   <= sat_r;
              state_r     <= S_IDLE;
            end else begin
              state_r <= S_HOLD;
            end
          end
        end
        S_HOLD: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_rps_r   <= speed_r;
            out_rpm_r   <= res_rsp.rpm;
            out_feed_r  <= res_rsp.feed;
            out_ready_r <= !warming_r;
            out_sat_r   <= sat_r;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_rps_x100     = out_rps_r;
  assign out_rpm          = out_rpm_r;
  assign out_feed_product = out_feed_r;
  assign out_ready_res    = out_ready_r;
  assign out_saturated    = out_sat_r;

  `SPT_ASSERT(a_acc_busy, in_acc |=> (state_r != S_IDLE), "accepted item left block idle")
  `SPT_ASSERT(a_sat_max, out_valid && out_saturated |-> out_rps_x100 == SPEED_MAX, "saturated below max")
  `SPT_ASSERT(a_rpm_le, out_valid |-> out_rpm <= out_rps_x100, "rpm exceeds rps_x100")
  `SPT_NEVER(a_start_excl, div_start_r && res_start_r, "divider and result unit started together")

endmodule

FILE: hw/rtl/sptach_div.sv
// Bit-serial restoring divider: speed numerator over the pulse interval.
module sptach_div
  import sptach_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                  busy_r;
  logic                  done_r;
  logic [DIV_CNT_W-1:0]  cnt_r;
  logic [NUM_BITS-1:0]   num_r;
  logic [NUM_BITS-1:0]   quo_r;
  logic [TIME_BITS-1:0]  rem_r;
  logic [TIME_BITS-1:0]  den_r;

  logic [TIME_BITS:0]    trial;
  logic [TIME_BITS:0]    diff;
  logic                  ge;
  logic [TIME_BITS-1:0]  rem_nxt;

  assign trial   = {rem_r, num_r[NUM_BITS-1]};
  assign diff    = trial - {1'b0, den_r};
  assign ge      = trial >= {1'b0, den_r};
  assign rem_nxt = ge ? diff[TIME_BITS-1:0] : trial[TIME_BITS-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(NUM_BITS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      num_r <= NUM_BITS'(SPEED_NUM);
      quo_r <= '0;
      rem_r <= '0;
      den_r <= req.den;
    end else if (busy_r) begin
      num_r <= {num_r[NUM_BITS-2:0], 1'b0};
      quo_r <= {quo_r[NUM_BITS-2:0], ge};
      rem_r <= rem_nxt;
    end
  end

  assign rsp.done = done_r;
  assign rsp.sat  = |quo_r[NUM_BITS-1:SPEED_W];
  assign rsp.quot = rsp.sat ? SPEED_MAX : quo_r[SPEED_W-1:0];

endmodule

FILE: hw/rtl/sptach_res.sv
// Bit-serial result unit: feed product by shift-add, rpm by serial divide by five.
module sptach_res
  import sptach_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  res_req_t req,
  output res_rsp_t rsp
);

  logic                  busy_r;
  logic                  done_r;
  logic [RES_CNT_W-1:0]  cnt_r;
  logic [SPEED_W-1:0]    mcand_r;
  logic [FEED_W-1:0]     prod_r;
  logic [RPM_X_W-1:0]    xs_r;
  logic [RPM_X_W-1:0]    rq_r;
  logic [RPM_REM_W-1:0]  rem_r;

  logic [SPEED_W:0]      psum;
  logic [FEED_W-1:0]     prod_nxt;
  logic [RPM_REM_W:0]    t;
  logic                  t_ge;
  logic [RPM_REM_W:0]    t_sub;
  logic [RPM_REM_W-1:0]  rem_nxt;
  logic [RPM_X_W-1:0]    x3;

  assign psum     = prod_r[0] ? ({1'b0, prod_r[FEED_W-1:SYNC_W]} + {1'b0, mcand_r})
                              : {1'b0, prod_r[FEED_W-1:SYNC_W]};
  assign prod_nxt = {psum, prod_r[SYNC_W-1:1]};

  assign t       = {rem_r, xs_r[RPM_X_W-1]};
  assign t_ge    = t >= (RPM_REM_W + 1)'(RPM_DIV);
  assign t_sub   = t - (RPM_REM_W + 1)'(RPM_DIV);
  assign rem_nxt = t_ge ? t_sub[RPM_REM_W-1:0] : t[RPM_REM_W-1:0];

  assign x3 = {1'b0, req.speed, 1'b0} + {2'b00, req.speed};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == RES_CNT_W'(RPM_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      mcand_r <= req.speed;
      prod_r  <= {{SPEED_W{1'b0}}, req.sync};
      xs_r    <= x3;
      rq_r    <= '0;
      rem_r   <= '0;
    end else if (busy_r) begin
      if (cnt_r < RES_CNT_W'(MUL_STEPS)) begin
        prod_r <= prod_nxt;
      end
      xs_r  <= {xs_r[RPM_X_W-2:0], 1'b0};
      rq_r  <= {rq_r[RPM_X_W-2:0], t_ge};
      rem_r <= rem_nxt;
    end
  end

  assign rsp.done = done_r;
  assign rsp.rpm  = rq_r[RPM_W-1:0];
  assign rsp.feed = prod_r;

endmodule

FILE: tb/sv/tb_spindle_period_tachometer_top.sv
// Self-checking testbench for the spindle period tachometer top level.
`timescale 1ns / 1ps

module tb_spindle_period_tachometer_top;
  import sptach_pkg::*;

  localparam logic [OP_W-1:0]   OP_SPARE    = 2'd3;
  localparam logic [SYNC_W-1:0] SYNC_TOP    = '1;
  localparam int                RANDOM_CMDS = 480;
  localparam int                IDLE_LIMIT  = 2000;
  localparam int                HOLD_CYCLES = 300;
  localparam int                HOLD_AT     = 40;
  localparam int                DRAIN_WAIT  = 100;

  typedef struct {
    logic [OP_W-1:0]   op;
    logic [TS_W-1:0]   ts;
    logic [SYNC_W-1:0] sync;
  } tach_cmd_t;

  typedef struct {
    logic [SPEED_W-1:0] rps;
    logic [RPM_W-1:0]   rpm;
    logic [FEED_W-1:0]  feed;
    logic               ready;
    logic               sat;
  } tach_reading_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [OP_W-1:0]     in_opcode = '0;
  logic [TS_W-1:0]     in_timestamp_us = '0;
  logic [SYNC_W-1:0]   in_feed_sync_speed = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [SPEED_W-1:0]  out_rps_x100;
  logic [RPM_W-1:0]    out_rpm;
  logic [FEED_W-1:0]   out_feed_product;
  logic                out_ready_res;
  logic                out_saturated;

  tach_cmd_t     tach_cmds[$];
  tach_reading_t due_readings[$];
  tach_cmd_t     cur_cmd;

  // predictor state
  logic [TIME_BITS-1:0] last_pulse;
  logic                 phase;
  logic                 warming;
  logic [SPEED_W-1:0]   speed;

  int unsigned tx_wait;
  int unsigned rx_wait;
  int unsigned rx_hold;
  int unsigned idle_cycles;
  logic        tx_calm;
  logic        rx_calm;
  logic        tx_fire;
  int          n_pulses;
  int          n_sat;
  int          n_restarts;
  int          n_reads;
  int          n_checked;
  int          n_errors;

  spindle_period_tachometer_top u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_opcode          (in_opcode),
    .in_timestamp_us    (in_timestamp_us),
    .in_feed_sync_speed (in_feed_sync_speed),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_rps_x100       (out_rps_x100),
    .out_rpm            (out_rpm),
    .out_feed_product   (out_feed_product),
    .out_ready_res      (out_ready_res),
    .out_saturated      (out_saturated)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic tach_reading_t advance_tach(tach_cmd_t c);
    tach_reading_t        r;
    logic [TIME_BITS-1:0] delta;
    logic [63:0]          q;
    r.sat = 1'b0;
    if (c.op == OP_PULSE) begin
      n_pulses++;
      delta = c.ts[TIME_BITS-1:0] - last_pulse;
      last_pulse = c.ts[TIME_BITS-1:0];
      if (!warming) begin
        if (delta == '0) begin
          speed = SPEED_MAX;
          r.sat = 1'b1;
        end else begin
          q = 64'(SPEED_NUM) / 64'(delta);
          if (q > 64'(SPEED_MAX)) begin
            speed = SPEED_MAX;
            r.sat = 1'b1;
          end else begin
            speed = q[SPEED_W-1:0];
          end
        end
      end
      if (!phase) begin
        phase = 1'b1;
      end else begin
        phase = 1'b0;
        warming = 1'b0;
      end
    end else if (c.op == OP_RESTART) begin
      n_restarts++;
      warming = 1'b1;
    end else begin
      n_reads++;
    end
    if (r.sat) n_sat++;
    r.rps   = speed;
    r.rpm   = RPM_W'((64'(speed) * 64'd60) / 64'd100);
    r.feed  = FEED_W'(64'(speed) * 64'(c.sync));
    r.ready = !warming;
    return r;
  endfunction

  task automatic add_cmd(logic [OP_W-1:0] op, logic [TS_W-1:0] ts, logic [SYNC_W-1:0] sync);
    tach_cmd_t c;
    c.op   = op;
    c.ts   = ts;
    c.sync = sync;
    tach_cmds.push_back(c);
  endtask

  function automatic logic [SYNC_W-1:0] pick_sync();
    int unsigned k;
    k = $urandom_range(0, 9);
    if (k == 0) return '0;
    if (k == 1) return SYNC_TOP;
    return SYNC_W'($urandom_range(0, 32767));
  endfunction

  function automatic logic [TS_W-1:0] pick_interval();
    int unsigned k;
    k = $urandom_range(0, 9);
    case (k)
      0: begin
        return '0;
      end
      1: begin
        return TS_W'($urandom_range(1, 1600));
      end
      2, 3, 4, 5: begin
        return TS_W'($urandom_range(1526, 100000));
      end
      6, 7: begin
        return TS_W'($urandom_range(100000, 100000000));
      end
      8: begin
        return TS_W'($urandom_range(100000001, 400000000));
      end
      default: begin
        return TS_W'($urandom);
      end
    endcase
  endfunction

  // stimulus, reset and end of run
  initial begin
    logic [TS_W-1:0] t;
    int unsigned     r;
    last_pulse = '0;
    phase      = 1'b0;
    warming    = 1'b1;
    speed      = '0;
    tx_calm    = 1'b0;
    rx_calm    = 1'b0;

    add_cmd(OP_STATUS, 32'd0, SYNC_TOP);
    add_cmd(OP_PULSE, 32'd0, 15'd0);
    add_cmd(OP_PULSE, 32'd1000, 15'd1);
    add_cmd(OP_PULSE, 32'd1000, SYNC_TOP);
    add_cmd(OP_PULSE, 32'd2526, SYNC_TOP);
    add_cmd(OP_PULSE, 32'd4051, 15'd100);
    t = 32'd4051 + 32'd100000000;
    add_cmd(OP_PULSE, t, 15'd3);
    t = t + 32'd200000000;
    add_cmd(OP_PULSE, t, 15'd3);
    add_cmd(OP_PULSE, 32'hFFFF_FFFF, SYNC_TOP);
    add_cmd(OP_PULSE, 32'h0000_03E7, SYNC_TOP);
    t = 32'h0000_03E7 + 32'd20000;
    add_cmd(OP_PULSE, t, 15'd1234);
    add_cmd(OP_RESTART, 32'h1234_5678, 15'd77);
    t = t + 32'd10000;
    add_cmd(OP_PULSE, t, 15'd500);
    add_cmd(OP_STATUS, t, 15'd500);
    t = t + 32'd10000;
    add_cmd(OP_PULSE, t, 15'd500);
    t = t + 32'd10000;
    add_cmd(OP_PULSE, t, SYNC_TOP);
    add_cmd(OP_RESTART, 32'd0, 15'd9);
    t = t + 32'd50000;
    add_cmd(OP_PULSE, t, 15'd4000);
    t = t + 32'd50000;
    add_cmd(OP_PULSE, t, 15'd4000);
    add_cmd(OP_SPARE, 32'hFFFF_FFFF, 15'h5555);
    add_cmd(OP_STATUS, 32'hAAAA_AAAA, 15'h2AAA);
    add_cmd(OP_RESTART, 32'h5555_5555, SYNC_TOP);

    for (int i = 0; i < RANDOM_CMDS; i++) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        t = t + pick_interval();
        add_cmd(OP_PULSE, t, pick_sync());
      end else if (r < 78) begin
        add_cmd(OP_RESTART, TS_W'($urandom), pick_sync());
      end else if (r < 88) begin
        add_cmd(OP_STATUS, TS_W'($urandom), pick_sync());
      end else if (r < 92) begin
        add_cmd(OP_SPARE, TS_W'($urandom), pick_sync());
      end else begin
        t = TS_W'($urandom);
        add_cmd(OP_PULSE, t, pick_sync());
      end
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (tach_cmds.size() != 0 || in_valid) @(posedge clk);
    while (due_readings.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Checked %0d readings: %0d pulses (%0d clamped), %0d restarts, %0d reads.",
             n_checked, n_pulses, n_sat, n_restarts, n_reads);
    $display("Covered warm-up, zero and short intervals, timestamp wrap and a long output hold-off.");
    if (n_errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      tx_wait = 0;
    end else begin
      tx_fire = in_valid && !in_stall;
      if (tx_fire) begin
        due_readings.push_back(advance_tach(cur_cmd));
      end
      if (in_valid && !tx_fire) begin
        // hold
      end else if (tx_wait > 0) begin
        tx_wait--;
        in_valid <= 1'b0;
      end else if (tach_cmds.size() != 0) begin
        cur_cmd = tach_cmds.pop_front();
        in_opcode          <= cur_cmd.op;
        in_timestamp_us    <= cur_cmd.ts;
        in_feed_sync_speed <= cur_cmd.sync;
        in_valid           <= 1'b1;
        if ($urandom_range(0, 15) == 0) tx_calm = !tx_calm;
        tx_wait = tx_calm ? 0 : $urandom_range(0, 4);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    tach_reading_t e;
    if (!rst_n) begin
      out_stall <= 1'b0;
      rx_wait = 0;
      rx_hold = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (due_readings.size() == 0) begin
          $error("unexpected reading: rps_x100 %0d", out_rps_x100);
          n_errors++;
        end else begin
          e = due_readings.pop_front();
          if (out_rps_x100 !== e.rps) begin
            $error("rps_x100: expected %0d, got %0d", e.rps, out_rps_x100);
            n_errors++;
          end
          if (out_rpm !== e.rpm) begin
            $error("rpm: expected %0d, got %0d", e.rpm, out_rpm);
            n_errors++;
          end
          if (out_feed_product !== e.feed) begin
            $error("feed_product: expected %0d, got %0d", e.feed, out_feed_product);
            n_errors++;
          end
          if (out_ready_res !== e.ready) begin
            $error("ready_res: expected %0b, got %0b", e.ready, out_ready_res);
            n_errors++;
          end
          if (out_saturated !== e.sat) begin
            $error("saturated: expected %0b, got %0b", e.sat, out_saturated);
            n_errors++;
          end
        end
        n_checked++;
        if (n_checked == HOLD_AT) rx_hold = HOLD_CYCLES;
        if ($urandom_range(0, 15) == 0) rx_calm = !rx_calm;
        rx_wait = rx_calm ? 0 : $urandom_range(0, 4);
      end
      if (rx_hold > 0) begin
        rx_hold--;
        out_stall <= 1'b1;
      end else if (rx_wait > 0) begin
        rx_wait--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/sptach_pkg.sv
hw/rtl/sptach_div.sv
hw/rtl/sptach_res.sv
hw/rtl/spindle_period_tachometer_top.sv
tb/sv/tb_spindle_period_tachometer_top.sv
